### hw/rtl/wsd_pkg.sv
package wsd_pkg;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [2:0] EXT_CNT_16  = 3'd1;
  localparam logic [2:0] EXT_CNT_64  = 3'd7;
  localparam logic [2:0] KEY_CNT_END = 3'd3;

  localparam logic [3:0] OPC_CLOSE = 4'h8;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef struct packed {
    logic       has;
    logic       kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       closed;
    logic [2:0] phase;
  } stat_t;

endpackage

### hw/rtl/wsd_byte_if.sv
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/wsd_result_if.sv
interface wsd_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;
  logic [3:0] frame_opcode;
  logic       frame_last;

  modport source (output valid, output kind, output data, output frame_opcode,
                  output frame_last, input ready);
  modport sink (input valid, input kind, input data, input frame_opcode,
                input frame_last, output ready);
endinterface

### hw/rtl/wsd_parser.sv
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output wsd_pkg::res_t    res,
  output wsd_pkg::stat_t   stat
);

  logic [2:0]  phase, phase_next;
  logic [3:0]  cur_opcode, cur_opcode_next;
  logic        is_masked, is_masked_next;
  logic [2:0]  ext_len_count, ext_len_count_next;
  logic [63:0] payload_length, payload_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic        closed, closed_next;
  logic        len_done;
  logic        frame_end;

  always_comb begin
    phase_next          = phase;
    cur_opcode_next     = cur_opcode;
    is_masked_next      = is_masked;
    ext_len_count_next  = ext_len_count;
    payload_length_next = payload_length;
    mask_key_next       = mask_key;
    closed_next         = closed;
    len_done            = 1'b0;
    frame_end           = 1'b0;
    res                 = '0;

    if (!closed) begin
      unique case (phase)
        wsd_pkg::PH_HDR0: begin
          cur_opcode_next = rx_byte[3:0];
          phase_next      = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          is_masked_next      = rx_byte[7];
          payload_length_next = '0;
          if (rx_byte[6:0] == wsd_pkg::LEN_CODE_16) begin
            ext_len_count_next = wsd_pkg::EXT_CNT_16;
            phase_next         = wsd_pkg::PH_EXT;
          end else if (rx_byte[6:0] == wsd_pkg::LEN_CODE_64) begin
            ext_len_count_next = wsd_pkg::EXT_CNT_64;
            phase_next         = wsd_pkg::PH_EXT;
          end else begin
            payload_length_next = {57'd0, rx_byte[6:0]};
            len_done            = 1'b1;
          end
        end
        wsd_pkg::PH_EXT: begin
          payload_length_next = {payload_length[55:0], rx_byte};
          if (ext_len_count == 3'd0) begin
            len_done = 1'b1;
          end else begin
            ext_len_count_next = ext_len_count - 3'd1;
          end
        end
        wsd_pkg::PH_KEY: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          if (ext_len_count == wsd_pkg::KEY_CNT_END) begin
            ext_len_count_next = 3'd0;
            if (payload_length == 64'd0) begin
              frame_end = 1'b1;
              res.has   = 1'b1;
              res.kind  = wsd_pkg::KIND_MARKER;
              res.last  = 1'b1;
            end else begin
              phase_next = wsd_pkg::PH_DATA;
            end
          end else begin
            ext_len_count_next = ext_len_count + 3'd1;
          end
        end
        wsd_pkg::PH_DATA: begin
          // rotate the key so the byte for the next index sits on top
          res.has             = 1'b1;
          res.kind            = wsd_pkg::KIND_DATA;
          res.data            = rx_byte ^ mask_key[31:24];
          res.last            = (payload_length == 64'd1);
          mask_key_next       = {mask_key[23:0], mask_key[31:24]};
          payload_length_next = payload_length - 64'd1;
          frame_end           = res.last;
        end
        default: begin
          phase_next = wsd_pkg::PH_HDR0;
        end
      endcase

      if (len_done) begin
        if (is_masked_next) begin
          phase_next         = wsd_pkg::PH_KEY;
          ext_len_count_next = 3'd0;
        end else begin
          mask_key_next = '0;
          if (payload_length_next == 64'd0) begin
            frame_end = 1'b1;
            res.has   = 1'b1;
            res.kind  = wsd_pkg::KIND_MARKER;
            res.last  = 1'b1;
          end else begin
            phase_next = wsd_pkg::PH_DATA;
          end
        end
      end

      if (frame_end) begin
        phase_next = wsd_pkg::PH_HDR0;
        if (cur_opcode == wsd_pkg::OPC_CLOSE) begin
          closed_next = 1'b1;
        end
      end
    end

    res.opcode = cur_opcode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= wsd_pkg::PH_HDR0;
      cur_opcode     <= '0;
      is_masked      <= 1'b0;
      ext_len_count  <= '0;
      payload_length <= '0;
      mask_key       <= '0;
      closed         <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      cur_opcode     <= cur_opcode_next;
      is_masked      <= is_masked_next;
      ext_len_count  <= ext_len_count_next;
      payload_length <= payload_length_next;
      mask_key       <= mask_key_next;
      closed         <= closed_next;
    end
  end

  assign stat.closed = closed;
  assign stat.phase  = phase;

endmodule

### hw/rtl/websocket_frame_deframer.sv
// Channel | Dir | Interface     | Payload
// rx      | in  | wsd_byte_if   | rx_byte[7:0]
// res     | out | wsd_result_if | kind, data[7:0], frame_opcode[3:0], frame_last
//
// One byte per clock sustained while res.ready stays high. A byte is held in
// the input register, is parsed by the header state logic and lands in the
// result register, from which the result is offered. Header bytes give no
// result but a marker beat on the last header byte of a zero-length frame;
// bytes after a completed close frame give no result.
// Reset (rst, synchronous) returns the parser to the first header byte.
// A stalled result holds the input register; rx.ready drops only while both
// registers are full and res.ready is low.
module websocket_frame_deframer (
  input  logic                clk,
  input  logic                rst,
  wsd_byte_if.sink            rx,
  wsd_result_if.source        res
);

  logic            in_valid;
  logic [7:0]      in_byte;
  logic            out_free;
  logic            step;
  wsd_pkg::res_t   parsed;
  wsd_pkg::stat_t  stat;
  logic            out_valid;
  wsd_pkg::res_t   out_res;

  assign out_free = !out_valid || res.ready;
  assign step     = in_valid && out_free;
  assign rx.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  wsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .res     (parsed),
    .stat    (stat)
  );

  // drop the result slot once taken, or when the parsed beat gives nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= parsed.has;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= parsed;
    end
  end

  assign res.valid        = out_valid;
  assign res.kind         = out_res.kind;
  assign res.data         = out_res.data;
  assign res.frame_opcode = out_res.opcode;
  assign res.frame_last   = out_res.last;

  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.kind == wsd_pkg::KIND_MARKER) |-> res.frame_last && (res.data == 8'd0))
    else $error("marker beat without last or with data");

  a_closed_sticky: assert property (@(posedge clk) disable iff (rst)
    stat.closed |=> stat.closed)
    else $error("closed flag cleared without reset");

  a_no_result_after_close: assert property (@(posedge clk) disable iff (rst)
    stat.closed && step |=> !out_valid)
    else $error("result produced after close frame");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    stat.phase <= wsd_pkg::PH_DATA)
    else $error("parser phase out of range");

endmodule
